// ----- sv/rgbhsv_pkg.sv -----
// rgbhsv_pkg: widths, pipeline stage record and per-stage arithmetic for the
// rgb to hsv pixel core. no dependencies; the interfaces and the core import it.
package rgbhsv_pkg;

  localparam int PIX_W    = 8;
  localparam int HUE_W    = 16;
  localparam int SAT_W    = 16;
  localparam int SAT_Q_W  = 16;                 // saturation quotient bits
  localparam int HUE_Q_W  = 13;                 // hue quotient bits, up to 4096
  localparam int SAT_N_W  = PIX_W + SAT_Q_W;    // delta * 65535
  localparam int DIV_OFS  = SAT_Q_W - HUE_Q_W;  // division stages with no hue step
  localparam int NUM_ST   = 2 + SAT_Q_W;        // front, divider setup, divider steps

  localparam logic [HUE_W-1:0] HUE_ONE = HUE_W'(4096);

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic [PIX_W-1:0]   mx;
    logic [PIX_W-1:0]   delta;
    sector_t            sector;
    logic               neg;
    logic [PIX_W-1:0]   mag;
    logic [PIX_W-1:0]   sat_rem;
    logic [SAT_Q_W-1:0] sat_qn;   // dividend bits leave at the top, quotient enters below
    logic [PIX_W-1:0]   hue_rem;
    logic [HUE_Q_W-1:0] hue_qn;
  } pix_stage_t;

  function automatic pix_stage_t front_calc(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                            logic [PIX_W-1:0] b);
    pix_stage_t       o;
    logic [PIX_W-1:0] mn;
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] c;
    o = '0;
    o.mx = (r > g) ? r : g;
    mn = (r < g) ? r : g;
    if (b > o.mx) o.mx = b;
    if (b < mn) mn = b;
    o.delta = o.mx - mn;
    // red tested first, then green on ties
    if (r >= g && r >= b) begin
      o.sector = SEC_RED;
      a = g;
      c = b;
    end else if (g >= b) begin
      o.sector = SEC_GREEN;
      a = b;
      c = r;
    end else begin
      o.sector = SEC_BLUE;
      a = r;
      c = g;
    end
    o.neg = (a < c);
    o.mag = o.neg ? (c - a) : (a - c);
    return o;
  endfunction

  function automatic pix_stage_t setup_calc(pix_stage_t s);
    pix_stage_t         o;
    logic [SAT_N_W-1:0] n;
    o = s;
    n = {s.delta, SAT_Q_W'(0)} - SAT_N_W'(s.delta);
    // top byte of delta*65535 is below max, so no quotient bits above bit 15
    o.sat_rem = n[SAT_N_W-1:SAT_Q_W];
    o.sat_qn  = n[SAT_Q_W-1:0];
    // mag <= delta, so mag/2 is below delta
    o.hue_rem = {1'b0, s.mag[PIX_W-1:1]};
    o.hue_qn  = {s.mag[0], (HUE_Q_W-1)'(0)};
    return o;
  endfunction

  function automatic pix_stage_t div_step(pix_stage_t s, logic hue_on);
    pix_stage_t     o;
    logic [PIX_W:0] t;
    logic [PIX_W:0] u;
    o = s;
    t = {s.sat_rem, s.sat_qn[SAT_Q_W-1]};
    if (t >= {1'b0, s.mx}) begin
      o.sat_rem = PIX_W'(t - {1'b0, s.mx});
      o.sat_qn  = {s.sat_qn[SAT_Q_W-2:0], 1'b1};
    end else begin
      o.sat_rem = t[PIX_W-1:0];
      o.sat_qn  = {s.sat_qn[SAT_Q_W-2:0], 1'b0};
    end
    if (hue_on) begin
      u = {s.hue_rem, s.hue_qn[HUE_Q_W-1]};
      if (u >= {1'b0, s.delta}) begin
        o.hue_rem = PIX_W'(u - {1'b0, s.delta});
        o.hue_qn  = {s.hue_qn[HUE_Q_W-2:0], 1'b1};
      end else begin
        o.hue_rem = u[PIX_W-1:0];
        o.hue_qn  = {s.hue_qn[HUE_Q_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic logic [HUE_W-1:0] hue_calc(pix_stage_t s);
    logic [HUE_W-1:0] ofs;
    logic [HUE_W-1:0] q;
    unique case (s.sector)
      SEC_RED:   ofs = '0;
      SEC_GREEN: ofs = HUE_W'(HUE_ONE << 1);
      SEC_BLUE:  ofs = HUE_W'(HUE_ONE << 2);
      default:   ofs = '0;
    endcase
    q = HUE_W'(s.hue_qn);
    return s.neg ? (ofs - q) : (ofs + q);
  endfunction

endpackage

// ----- sv/rgbhsv_if.sv -----
// rgbhsv_if: valid/ready channel interfaces for rgb pixels in and hsv results out.
// depends on rgbhsv_pkg for the field widths.
interface rgbhsv_pix_in_if;
  logic                         valid;
  logic                         ready;
  logic [rgbhsv_pkg::PIX_W-1:0] red;
  logic [rgbhsv_pkg::PIX_W-1:0] green;
  logic [rgbhsv_pkg::PIX_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsv_pix_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rgbhsv_pkg::HUE_W-1:0] hue_times_three;
  logic [rgbhsv_pkg::SAT_W-1:0]        saturation;
  logic [rgbhsv_pkg::PIX_W-1:0]        brightness;

  modport source (output valid, output hue_times_three, output saturation,
                  output brightness, input ready);
  modport sink   (input valid, input hue_times_three, input saturation,
                  input brightness, output ready);
endinterface

// ----- sv/rgb_to_hsv_pixel_core.sv -----
// rgb_to_hsv_pixel_core: pipelined rgb to hsv converter, one pixel a cycle while unstalled.
// depends on rgbhsv_pkg and the channel interfaces in rgbhsv_if.sv.
//
//   channel   dir  request payload
//   pix_in    in   red, green, blue (8 bits each)
//   pix_out   out  hue_times_three (s16 q3.12), saturation (u16), brightness (u8)
//
// one pixel accepted per cycle while the output is not stalled; a pixel passes the front and
// setup stages, the 16 steps of the two bit-per-stage dividers, then the output register.
// rst is synchronous and clears only the stage valid bits and the output valid.
// each stage moves on when it is empty or the one after it moves, so a stalled
// output lets bubbles close up and no request is lost or repeated.
module rgb_to_hsv_pixel_core (
  input logic                clk,
  input logic                rst,
  rgbhsv_pix_in_if.sink      pix_in,
  rgbhsv_pix_out_if.source   pix_out
);
  import rgbhsv_pkg::*;

  pix_stage_t        st [NUM_ST];
  logic [NUM_ST-1:0] v;
  logic [NUM_ST-1:0] adv;
  logic              out_en;
  logic              out_v;

  assign out_en = !out_v || pix_out.ready;

  // a stage may load if any stage from it to the end is empty, or the output drains
  for (genvar i = 0; i < NUM_ST; i++) begin : g_adv
    assign adv[i] = out_en || !(&v[NUM_ST-1:i]);
  end

  assign pix_in.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v     <= '0;
      out_v <= 1'b0;
    end else begin
      if (adv[0]) v[0] <= pix_in.valid;
      for (int i = 1; i < NUM_ST; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
      if (out_en) out_v <= v[NUM_ST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && pix_in.valid) st[0] <= front_calc(pix_in.red, pix_in.green, pix_in.blue);
  end

  always_ff @(posedge clk) begin
    if (adv[1] && v[0]) st[1] <= setup_calc(st[0]);
  end

  // division step k = i-1; hue needs only the last HUE_Q_W steps
  for (genvar i = 2; i < NUM_ST; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv[i] && v[i-1]) st[i] <= div_step(st[i-1], 1'((i - 1) > DIV_OFS));
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && v[NUM_ST-1]) begin
      if (st[NUM_ST-1].delta == '0) begin
        pix_out.hue_times_three <= '0;
        pix_out.saturation      <= '0;
      end else begin
        pix_out.hue_times_three <= hue_calc(st[NUM_ST-1]);
        pix_out.saturation      <= st[NUM_ST-1].sat_qn;
      end
      pix_out.brightness <= st[NUM_ST-1].mx;
    end
  end

  assign pix_out.valid = out_v;

  a_black_zero: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && pix_out.brightness == '0 |->
      pix_out.saturation == '0 && pix_out.hue_times_three == '0)
    else $error("black pixel gave nonzero hue or saturation");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |->
      pix_out.hue_times_three >= -16'sd4096 && pix_out.hue_times_three <= 16'sd20480)
    else $error("hue out of range");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(out_v) |-> $past(v[NUM_ST-1]))
    else $error("output valid without a request in the last stage");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    pix_in.valid && pix_in.ready |=> v[0])
    else $error("accepted request not held in front stage");

endmodule

// ----- dv/rgb_to_hsv_pixel_core_test.sv -----
// rgb_to_hsv_pixel_core_test: self-checking bench for the rgb to hsv pixel core.
// walks a table of corner pixels, then random pixels under varying back-pressure.
// depends on rgbhsv_pkg, the channel interfaces in rgbhsv_if.sv and the core.
module rgb_to_hsv_pixel_core_test;
  import rgbhsv_pkg::*;

  localparam int  DIRECTED_ROWS = 25;
  localparam int  RANDOM_PER_PHASE = 170;
  localparam int  HOLD_OFF_CYCLES = 200;
  localparam int  DRAIN_CYCLES = 40;
  localparam int  CYCLE_LIMIT = 200000;
  localparam bit  BY_HAND = 1'b1;
  localparam bit  PREDICT = 1'b0;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [PIX_W-1:0] bright;
  } hsv_pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    bit               typed;
    hsv_pixel_t       hsv;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst;

  rgbhsv_pix_in_if  pix_in ();
  rgbhsv_pix_out_if pix_out ();

  rgb_to_hsv_pixel_core dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out)
  );

  always #2 clk = ~clk;

  hsv_pixel_t hsv_pending[$];
  int         error_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         idle_phase = 0;
  int         hold_left = 0;
  bit         held_once = 1'b0;

  pixel_row_t pixel_table [DIRECTED_ROWS] = '{
    '{8'd0,   8'd0,   8'd0,   BY_HAND, '{16'd0,     16'd0,     8'd0}},
    '{8'd255, 8'd255, 8'd255, BY_HAND, '{16'd0,     16'd0,     8'd255}},
    '{8'd128, 8'd128, 8'd128, BY_HAND, '{16'd0,     16'd0,     8'd128}},
    '{8'd1,   8'd1,   8'd1,   BY_HAND, '{16'd0,     16'd0,     8'd1}},
    '{8'd255, 8'd0,   8'd0,   BY_HAND, '{16'd0,     16'd65535, 8'd255}},
    '{8'd0,   8'd255, 8'd0,   BY_HAND, '{16'd8192,  16'd65535, 8'd255}},
    '{8'd0,   8'd0,   8'd255, BY_HAND, '{16'd16384, 16'd65535, 8'd255}},
    '{8'd255, 8'd255, 8'd0,   BY_HAND, '{16'd4096,  16'd65535, 8'd255}},
    '{8'd0,   8'd255, 8'd255, BY_HAND, '{16'd12288, 16'd65535, 8'd255}},
    // red wins the tie with blue, so the hue goes to its negative extreme
    '{8'd255, 8'd0,   8'd255, BY_HAND, '{16'hF000,  16'd65535, 8'd255}},
    '{8'd1,   8'd0,   8'd0,   BY_HAND, '{16'd0,     16'd65535, 8'd1}},
    '{8'd0,   8'd1,   8'd0,   BY_HAND, '{16'd8192,  16'd65535, 8'd1}},
    '{8'd0,   8'd0,   8'd1,   BY_HAND, '{16'd16384, 16'd65535, 8'd1}},
    '{8'd254, 8'd0,   8'd255, PREDICT, '0},
    '{8'd255, 8'd0,   8'd1,   PREDICT, '0},
    '{8'd10,  8'd3,   8'd0,   PREDICT, '0},
    '{8'd10,  8'd0,   8'd3,   PREDICT, '0},
    '{8'd1,   8'd2,   8'd3,   PREDICT, '0},
    '{8'd255, 8'd254, 8'd0,   PREDICT, '0},
    '{8'd128, 8'd255, 8'd127, PREDICT, '0},
    '{8'd200, 8'd100, 8'd150, PREDICT, '0},
    '{8'd3,   8'd255, 8'd254, PREDICT, '0},
    '{8'd255, 8'd1,   8'd254, PREDICT, '0},
    '{8'd127, 8'd128, 8'd128, PREDICT, '0},
    '{8'd85,  8'd170, 8'd255, PREDICT, '0}
  };

  function automatic hsv_pixel_t convert_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                               logic [PIX_W-1:0] b);
    hsv_pixel_t res;
    sector_t    sector;
    int         mx;
    int         mn;
    int         delta;
    int         diff;
    int         quot;
    int         offset;
    mx = (r > g) ? int'(r) : int'(g);
    mn = (r < g) ? int'(r) : int'(g);
    if (int'(b) > mx) mx = int'(b);
    if (int'(b) < mn) mn = int'(b);
    delta = mx - mn;
    res = '0;
    res.bright = PIX_W'(mx);
    if (delta != 0) begin
      res.sat = SAT_W'((delta * 65535) / mx);
      if (int'(r) >= mx) sector = SEC_RED;
      else if (int'(g) >= mx) sector = SEC_GREEN;
      else sector = SEC_BLUE;
      case (sector)
        SEC_RED: begin
          offset = 0;
          diff = int'(g) - int'(b);
        end
        SEC_GREEN: begin
          offset = 2;
          diff = int'(b) - int'(r);
        end
        default: begin
          offset = 4;
          diff = int'(r) - int'(g);
        end
      endcase
      // quotient of the magnitude, so the sign truncates toward zero
      quot = (((diff < 0) ? -diff : diff) * 4096) / delta;
      res.hue = HUE_W'(offset * 4096 + ((diff < 0) ? -quot : quot));
    end
    return res;
  endfunction

  task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b,
                            hsv_pixel_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(negedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.red   <= r;
    pix_in.green <= g;
    pix_in.blue  <= b;
    do @(posedge clk); while (!pix_in.ready);
    hsv_pending.push_back(want);
    @(negedge clk);
  endtask

  // receiver side: random idling plus one long hold-off when the last phase opens
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      pix_out.ready <= 1'b0;
    end else if (idle_phase == 2 && !held_once) begin
      held_once = 1'b1;
      hold_left = HOLD_OFF_CYCLES - 1;
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    hsv_pixel_t want;
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (hsv_pending.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        want = hsv_pending.pop_front();
        if (pix_out.hue_times_three !== want.hue) begin
          $error("hue_times_three: expected %0d, got %0d", $signed(want.hue),
                 pix_out.hue_times_three);
          error_count++;
        end
        if (pix_out.saturation !== want.sat) begin
          $error("saturation: expected %0d, got %0d", want.sat, pix_out.saturation);
          error_count++;
        end
        if (pix_out.brightness !== want.bright) begin
          $error("brightness: expected %0d, got %0d", want.bright, pix_out.brightness);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin
    pixel_row_t       row;
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    rst = 1'b1;
    pix_in.valid = 1'b0;
    pix_in.red = '0;
    pix_in.green = '0;
    pix_in.blue = '0;
    pix_out.ready = 1'b0;
    send_idle_pct = 25;
    recv_idle_pct = 61;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (pixel_table[i]) begin
      row = pixel_table[i];
      send_pixel(row.red, row.green, row.blue,
                 row.typed ? row.hsv : convert_pixel(row.red, row.green, row.blue));
    end

    for (int phase = 0; phase < 3; phase++) begin
      idle_phase = phase;
      send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 61 : 0;
      recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 25 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        r = PIX_W'($urandom);
        g = PIX_W'($urandom);
        b = PIX_W'($urandom);
        case ($urandom_range(9))
          0: begin
            g = r;
            b = r;
          end
          // paired channels; where the pair is the top, the tie decides the sector order
          1: g = r;
          2: b = g;
          3: b = r;
          4: begin
            r = $urandom_range(1) ? 8'd255 : 8'd0;
            g = $urandom_range(1) ? 8'd255 : PIX_W'($urandom_range(3));
          end
          default: ;
        endcase
        send_pixel(r, g, b, convert_pixel(r, g, b));
      end
    end
    pix_in.valid <= 1'b0;

    while (hsv_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
